[rtl/amdfs_pkg.sv]
// Shared types and constants for the adjacency matrix depth-first walk block.
`default_nettype none
package amdfs_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VERT_W       = 4;
    localparam int CNT_W        = 5;
    localparam int WEIGHT_W     = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 5;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_VISIT  = 1'b1;

    typedef logic [VERT_W-1:0]       t_vertex;
    typedef logic [MAX_VERTICES-1:0] t_vmask;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        t_vertex          start_v;
    } t_cfg;

    typedef struct packed {
        t_vertex from_v;
        t_vertex to_v;
        logic    nz;
        logic    ok;
        logic    last;
    } t_edge;

    typedef struct packed {
        logic    kind;
        logic    ok;
        t_vertex vertex;
        logic    end_of_run;
    } t_result;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_WALK
    } t_walk_state;

endpackage
`default_nettype wire

[rtl/amdfs_front.sv]
// Front end: configuration registers, item accept and edge classification.
`default_nettype none
module amdfs_front (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [amdfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [amdfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire                                i_start,
    input  wire                                i_full,
    input  wire [amdfs_pkg::VERT_W-1:0]        i_from_vertex,
    input  wire [amdfs_pkg::VERT_W-1:0]        i_to_vertex,
    input  wire [amdfs_pkg::WEIGHT_W-1:0]      i_weight,
    input  wire                                i_last,
    output amdfs_pkg::t_cfg                    o_cfg,
    output logic                               o_push,
    output amdfs_pkg::t_edge                   o_edge
);

    logic [amdfs_pkg::CNT_W-1:0] r_vertex_count;
    amdfs_pkg::t_vertex          r_start_vertex;
    logic [amdfs_pkg::CNT_W-1:0] n_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= '0;
            r_start_vertex <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                amdfs_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data;
                amdfs_pkg::CFG_START_VERTEX:
                    r_start_vertex <= i_cfg_data[amdfs_pkg::VERT_W-1:0];
                default: ;
            endcase
        end
    end

    // counts beyond the matrix size clamp to it
    always_comb begin
        if (r_vertex_count > amdfs_pkg::CNT_W'(amdfs_pkg::MAX_VERTICES)) begin
            n_eff = amdfs_pkg::CNT_W'(amdfs_pkg::MAX_VERTICES);
        end else begin
            n_eff = r_vertex_count;
        end
    end

    assign o_cfg.n       = n_eff;
    assign o_cfg.start_v = r_start_vertex;

    assign o_push        = i_start && !i_full;
    assign o_edge.from_v = i_from_vertex;
    assign o_edge.to_v   = i_to_vertex;
    assign o_edge.nz     = (i_weight != '0);
    assign o_edge.ok     = ({1'b0, i_from_vertex} < n_eff) && ({1'b0, i_to_vertex} < n_eff);
    assign o_edge.last   = i_last;

endmodule
`default_nettype wire

[rtl/amdfs_queue.sv]
// Short item queue between the front end and the walk engine.
`default_nettype none
module amdfs_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  amdfs_pkg::t_edge  i_edge,
    input  wire               i_pop,
    output logic              o_full,
    output logic              o_empty,
    output amdfs_pkg::t_edge  o_head
);

    amdfs_pkg::t_edge                r_mem [amdfs_pkg::QUEUE_DEPTH];
    logic [amdfs_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [amdfs_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [amdfs_pkg::QCNT_W-1:0]    r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == amdfs_pkg::QCNT_W'(amdfs_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_edge;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/amdfs_walk.sv]
// Back end: edge matrix, depth-first walk engine and result register.
`default_nettype none
module amdfs_walk (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  amdfs_pkg::t_cfg   i_cfg,
    input  wire               i_empty,
    input  amdfs_pkg::t_edge  i_head,
    output logic              o_pop,
    output logic              o_valid,
    output amdfs_pkg::t_result o_result
);

    amdfs_pkg::t_walk_state      r_state;
    amdfs_pkg::t_walk_state      n_state;
    // row i holds edges i->j, col j holds the same bits transposed
    amdfs_pkg::t_vmask           r_row [amdfs_pkg::MAX_VERTICES];
    amdfs_pkg::t_vmask           r_col [amdfs_pkg::MAX_VERTICES];
    amdfs_pkg::t_vmask           r_visited;
    amdfs_pkg::t_vertex          r_stack [amdfs_pkg::MAX_VERTICES];
    logic [amdfs_pkg::CNT_W-1:0] r_depth;
    amdfs_pkg::t_result          r_pend;
    amdfs_pkg::t_result          r_out;
    logic                        r_out_valid;

    logic [amdfs_pkg::CNT_W-1:0] top_idx;
    amdfs_pkg::t_vertex          top_v;
    amdfs_pkg::t_vmask           in_range;
    amdfs_pkg::t_vmask           cand;
    logic                        found;
    amdfs_pkg::t_vertex          found_j;
    logic                        start_ok;
    logic                        walk_done;
    logic                        clear_all;
    logic                        emit;
    amdfs_pkg::t_result          emit_res;

    assign top_idx   = r_depth - 1'b1;
    assign top_v     = r_stack[top_idx[amdfs_pkg::VERT_W-1:0]];
    assign start_ok  = ({1'b0, i_cfg.start_v} < i_cfg.n);
    assign walk_done = (r_depth == '0);

    always_comb begin
        for (int k = 0; k < amdfs_pkg::MAX_VERTICES; k++) begin
            in_range[k] = (amdfs_pkg::CNT_W'(k) < i_cfg.n);
        end
    end

    assign cand = (r_row[top_v] ^ r_col[top_v]) & ~r_visited & in_range;

    always_comb begin
        found   = 1'b0;
        found_j = '0;
        for (int k = amdfs_pkg::MAX_VERTICES - 1; k >= 0; k--) begin
            if (cand[k]) begin
                found   = 1'b1;
                found_j = amdfs_pkg::VERT_W'(k);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            amdfs_pkg::ST_IDLE: begin
                if (!i_empty && i_head.last) begin
                    n_state = amdfs_pkg::ST_INIT;
                end
            end
            amdfs_pkg::ST_INIT: begin
                n_state = start_ok ? amdfs_pkg::ST_WALK : amdfs_pkg::ST_IDLE;
            end
            amdfs_pkg::ST_WALK: begin
                if (walk_done) begin
                    n_state = amdfs_pkg::ST_IDLE;
                end
            end
            default: n_state = amdfs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        clear_all = 1'b0;
        emit      = 1'b0;
        emit_res  = r_pend;
        unique case (r_state)
            amdfs_pkg::ST_IDLE: begin
                o_pop               = !i_empty;
                emit                = !i_empty && !i_head.last;
                emit_res.kind       = amdfs_pkg::KIND_STATUS;
                emit_res.ok         = i_head.ok;
                emit_res.vertex     = '0;
                emit_res.end_of_run = 1'b1;
            end
            amdfs_pkg::ST_INIT: begin
                emit                = !start_ok;
                clear_all           = !start_ok;
                emit_res.end_of_run = 1'b1;
            end
            amdfs_pkg::ST_WALK: begin
                emit                = walk_done || found;
                clear_all           = walk_done;
                emit_res.end_of_run = walk_done;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= amdfs_pkg::ST_IDLE;
            r_visited   <= '0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < amdfs_pkg::MAX_VERTICES; i++) begin
                r_row[i] <= '0;
                r_col[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= emit;
            if (clear_all) begin
                r_visited <= '0;
                r_depth   <= '0;
                for (int i = 0; i < amdfs_pkg::MAX_VERTICES; i++) begin
                    r_row[i] <= '0;
                    r_col[i] <= '0;
                end
            end else begin
                unique case (r_state)
                    amdfs_pkg::ST_IDLE: begin
                        if (!i_empty && i_head.ok) begin
                            r_row[i_head.from_v][i_head.to_v] <= i_head.nz;
                            r_col[i_head.to_v][i_head.from_v] <= i_head.nz;
                        end
                    end
                    amdfs_pkg::ST_INIT: begin
                        r_visited <= amdfs_pkg::t_vmask'(1) << i_cfg.start_v;
                        r_depth   <= amdfs_pkg::CNT_W'(1);
                    end
                    amdfs_pkg::ST_WALK: begin
                        if (found) begin
                            r_visited[found_j] <= 1'b1;
                            if (!r_depth[amdfs_pkg::CNT_W-1]) begin
                                r_depth <= r_depth + 1'b1;
                            end
                        end else begin
                            r_depth <= r_depth - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= emit_res;
        end
        unique case (r_state)
            amdfs_pkg::ST_IDLE: begin
                r_pend.kind       <= amdfs_pkg::KIND_STATUS;
                r_pend.ok         <= i_head.ok;
                r_pend.vertex     <= '0;
                r_pend.end_of_run <= 1'b0;
            end
            amdfs_pkg::ST_INIT: begin
                r_stack[0] <= i_cfg.start_v;
            end
            amdfs_pkg::ST_WALK: begin
                if (found) begin
                    r_pend.kind       <= amdfs_pkg::KIND_VISIT;
                    r_pend.ok         <= 1'b0;
                    r_pend.vertex     <= found_j;
                    r_pend.end_of_run <= 1'b0;
                    if (!r_depth[amdfs_pkg::CNT_W-1]) begin
                        r_stack[r_depth[amdfs_pkg::VERT_W-1:0]] <= found_j;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

[rtl/adjacency_matrix_dfs.sv]
// Top level of the adjacency matrix depth-first walk block.
// An edge item's status passes through the item queue and the result register; edges stream
// at one per cycle while busy is low. An item with last runs the walk: setup, then steps that
// each visit a vertex or backtrack till the stack empties; the final result carries end_of_run.
// busy is high while the four-entry item queue is full.
// Synchronous active-low reset clears configuration, the edge matrix and the queue.
`default_nettype none
module adjacency_matrix_dfs (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [amdfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [amdfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              start,
    output logic                             busy,
    input  wire [amdfs_pkg::VERT_W-1:0]      i_from_vertex,
    input  wire [amdfs_pkg::VERT_W-1:0]      i_to_vertex,
    input  wire [amdfs_pkg::WEIGHT_W-1:0]    i_weight,
    input  wire                              i_last,
    output logic                             o_valid,
    output logic                             o_kind,
    output logic                             o_ok,
    output logic [amdfs_pkg::VERT_W-1:0]     o_vertex,
    output logic                             o_end_of_run
);

    amdfs_pkg::t_cfg    cfg;
    amdfs_pkg::t_edge   push_edge;
    amdfs_pkg::t_edge   head;
    amdfs_pkg::t_result result;
    logic               push;
    logic               pop;
    logic               full;
    logic               empty;

    amdfs_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start       (start),
        .i_full        (full),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_weight      (i_weight),
        .i_last        (i_last),
        .o_cfg         (cfg),
        .o_push        (push),
        .o_edge        (push_edge)
    );

    amdfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_edge  (push_edge),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    amdfs_walk u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_empty  (empty),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_result (result)
    );

    assign busy         = full;
    assign o_kind       = result.kind;
    assign o_ok         = result.ok;
    assign o_vertex     = result.vertex;
    assign o_end_of_run = result.end_of_run;

endmodule
`default_nettype wire

[bench/amdfs_checker.sv]
// Checker for the depth-first walk block: predicts status and visit results and compares them.
module amdfs_checker (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [amdfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [amdfs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                              i_start,
    input  wire                              i_busy,
    input  wire [amdfs_pkg::VERT_W-1:0]      i_from_vertex,
    input  wire [amdfs_pkg::VERT_W-1:0]      i_to_vertex,
    input  wire [amdfs_pkg::WEIGHT_W-1:0]    i_weight,
    input  wire                              i_last,
    input  wire                              i_res_valid,
    input  wire                              i_res_kind,
    input  wire                              i_res_ok,
    input  wire [amdfs_pkg::VERT_W-1:0]      i_res_vertex,
    input  wire                              i_res_end,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 16;
    localparam int STACK_DEPTH  = 16;
    localparam int SHOW_LIMIT   = 10;

    logic [amdfs_pkg::WEIGHT_W-1:0] weight_store [amdfs_pkg::MAX_VERTICES][amdfs_pkg::MAX_VERTICES];
    logic [amdfs_pkg::CNT_W-1:0]    vertex_count;
    amdfs_pkg::t_vertex             start_vertex;
    amdfs_pkg::t_result             due_results [$];
    int                             mismatches;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        mismatches    = 0;
    end

    function automatic logic linked(input amdfs_pkg::t_vertex a, input amdfs_pkg::t_vertex b);
        return (weight_store[a][b] != '0) != (weight_store[b][a] != '0);
    endfunction

    // store one edge and, on last, walk the graph and clear the store
    function automatic void load_edge(input amdfs_pkg::t_vertex from_v,
                                      input amdfs_pkg::t_vertex to_v,
                                      input logic [amdfs_pkg::WEIGHT_W-1:0] w,
                                      input logic last);
        int                 n;
        int                 depth;
        int                 top;
        int                 j;
        int                 nres;
        amdfs_pkg::t_vertex v;
        amdfs_pkg::t_vmask  seen;
        amdfs_pkg::t_vertex stk_v [STACK_DEPTH];
        int                 stk_next [STACK_DEPTH];
        amdfs_pkg::t_result r;
        logic               stored;

        n = (int'(vertex_count) < amdfs_pkg::MAX_VERTICES) ?
            int'(vertex_count) : amdfs_pkg::MAX_VERTICES;
        stored = (int'(from_v) < n) && (int'(to_v) < n);
        if (stored) begin
            weight_store[from_v][to_v] = w;
        end
        r = '{kind: amdfs_pkg::KIND_STATUS, ok: stored, vertex: '0, end_of_run: 1'b0};
        due_results.push_back(r);
        if (last) begin
            seen  = '0;
            depth = 0;
            nres  = 1;
            if (int'(start_vertex) < n) begin
                seen[start_vertex] = 1'b1;
                stk_v[0]    = start_vertex;
                stk_next[0] = 0;
                depth       = 1;
            end
            while (depth > 0 && nres < REPORT_LIMIT) begin
                top = depth - 1;
                v   = stk_v[top];
                j   = stk_next[top];
                while (j < n && (seen[j] || !linked(v, amdfs_pkg::t_vertex'(j)))) begin
                    j++;
                end
                if (j >= n) begin
                    depth--;
                end else begin
                    stk_next[top] = j + 1;
                    seen[j] = 1'b1;
                    r = '{kind: amdfs_pkg::KIND_VISIT, ok: 1'b0,
                          vertex: amdfs_pkg::t_vertex'(j), end_of_run: 1'b0};
                    due_results.push_back(r);
                    nres++;
                    if (depth < STACK_DEPTH) begin
                        stk_v[depth]    = amdfs_pkg::t_vertex'(j);
                        stk_next[depth] = 0;
                        depth++;
                    end
                end
            end
            foreach (weight_store[a, b]) begin
                weight_store[a][b] = '0;
            end
        end
        r = due_results.pop_back();
        r.end_of_run = 1'b1;
        due_results.push_back(r);
    endfunction

    task automatic note_mismatch(input string what, input amdfs_pkg::t_result want,
                                 input amdfs_pkg::t_result got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) begin
            $display("%0t %s: expected kind=%0d ok=%0d vertex=%0d end=%0d, %s",
                     $realtime, what, want.kind, want.ok, want.vertex, want.end_of_run,
                     $sformatf("got kind=%0d ok=%0d vertex=%0d end=%0d",
                               got.kind, got.ok, got.vertex, got.end_of_run));
        end
    endtask

    always @(posedge i_clk) begin
        amdfs_pkg::t_result got;
        amdfs_pkg::t_result want;
        if (!i_rst_n) begin
            foreach (weight_store[a, b]) begin
                weight_store[a][b] = '0;
            end
            vertex_count = '0;
            start_vertex = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    amdfs_pkg::CFG_VERTEX_COUNT: vertex_count = i_cfg_data;
                    amdfs_pkg::CFG_START_VERTEX:
                        start_vertex = i_cfg_data[amdfs_pkg::VERT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                load_edge(i_from_vertex, i_to_vertex, i_weight, i_last);
            end
            if (i_res_valid) begin
                got = '{kind: i_res_kind, ok: i_res_ok, vertex: i_res_vertex,
                        end_of_run: i_res_end};
                if (due_results.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        note_mismatch("result mismatch", want, got);
                    end
                end
            end
        end
        o_outstanding <= due_results.size();
        o_mismatches  <= mismatches;
    end

endmodule

[bench/tb.sv]
// Top of the testbench: clock, reset, edge and config stimulus, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 350;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_GAP      = 12;
    localparam int SETTLE       = 60;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [amdfs_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [amdfs_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                             start;
    logic                             busy;
    amdfs_pkg::t_vertex               i_from_vertex;
    amdfs_pkg::t_vertex               i_to_vertex;
    logic [amdfs_pkg::WEIGHT_W-1:0]   i_weight;
    logic                             i_last;
    logic                             o_valid;
    logic                             o_kind;
    logic                             o_ok;
    amdfs_pkg::t_vertex               o_vertex;
    logic                             o_end_of_run;
    int                               mismatches;
    int                               outstanding;
    int                               stall_cycles;
    int                               random_items;

    adjacency_matrix_dfs uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .start         (start),
        .busy          (busy),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_weight      (i_weight),
        .i_last        (i_last),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_ok          (o_ok),
        .o_vertex      (o_vertex),
        .o_end_of_run  (o_end_of_run)
    );

    amdfs_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_start       (start),
        .i_busy        (busy),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_weight      (i_weight),
        .i_last        (i_last),
        .i_res_valid   (o_valid),
        .i_res_kind    (o_kind),
        .i_res_ok      (o_ok),
        .i_res_vertex  (o_vertex),
        .i_res_end     (o_end_of_run),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial stall_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("tb: FAIL");
        $finish;
    end

    // leaves start high after acceptance so back-to-back items need no dip
    task automatic send_edge(input amdfs_pkg::t_vertex f, input amdfs_pkg::t_vertex t,
                             input logic [amdfs_pkg::WEIGHT_W-1:0] w,
                             input logic l, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start         <= 1'b1;
        i_from_vertex <= f;
        i_to_vertex   <= t;
        i_weight      <= w;
        i_last        <= l;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_graph_config(input logic [amdfs_pkg::CFG_DATA_W-1:0] count_word,
                                    input logic [amdfs_pkg::CFG_DATA_W-1:0] start_word);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= amdfs_pkg::CFG_VERTEX_COUNT;
        i_cfg_data <= count_word;
        @(posedge i_clk);
        i_cfg_idx  <= amdfs_pkg::CFG_START_VERTEX;
        i_cfg_data <= start_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic directed_items();
        // default config after reset: no vertices, edge rejected, walk reports nothing
        send_edge(4'd15, 4'd15, 16'hFFFF, 1'b1, 0);
        wait_idle();
        // full chain: hits the report limit and the deepest stack
        set_graph_config(5'd16, 5'd0);
        for (int i = 0; i < amdfs_pkg::MAX_VERTICES - 1; i++) begin
            send_edge(amdfs_pkg::t_vertex'(i), amdfs_pkg::t_vertex'(i + 1),
                      (i % 2 == 1) ? 16'hFFFF : 16'(1 << i),
                      i == amdfs_pkg::MAX_VERTICES - 2, 0);
        end
        wait_idle();
        // count beyond limit, zero weight, reverse-only link, mutual pair, self loop
        set_graph_config(5'd31, 5'b10101);
        send_edge(4'd5, 4'd6, 16'h0000, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd6, 4'd5, 16'h0007, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd5, 4'd7, 16'h0003, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd7, 4'd5, 16'h0003, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd5, 4'd5, 16'h0009, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd6, 4'd9, 16'h1234, 1'b0, $urandom_range(0, MAX_GAP));
        send_edge(4'd9, 4'd15, 16'hFFFF, 1'b1, $urandom_range(0, MAX_GAP));
        wait_idle();
        // start out of range, rejected edge before the walk
        set_graph_config(5'd3, 5'd7);
        send_edge(4'd0, 4'd9, 16'h0005, 1'b0, 0);
        send_edge(4'd1, 4'd2, 16'h0004, 1'b1, 0);
        wait_idle();
    endtask

    task automatic random_graph();
        int                             count_cfg;
        int                             n;
        int                             n_edges;
        int                             gap_mode;
        int                             gap;
        int                             pick;
        amdfs_pkg::t_vertex             start_v;
        amdfs_pkg::t_vertex             f;
        amdfs_pkg::t_vertex             t;
        amdfs_pkg::t_vertex             prev_f;
        amdfs_pkg::t_vertex             prev_t;
        logic [amdfs_pkg::WEIGHT_W-1:0] w;
        logic                           l;

        pick = $urandom_range(0, 9);
        case (pick)
            0:       count_cfg = $urandom_range(0, 1);
            1:       count_cfg = $urandom_range(17, 31);
            2:       count_cfg = amdfs_pkg::MAX_VERTICES;
            default: count_cfg = $urandom_range(2, amdfs_pkg::MAX_VERTICES);
        endcase
        n = (count_cfg < amdfs_pkg::MAX_VERTICES) ? count_cfg : amdfs_pkg::MAX_VERTICES;
        if (n > 0 && $urandom_range(0, 7) != 0) begin
            start_v = amdfs_pkg::t_vertex'($urandom_range(0, n - 1));
        end else begin
            start_v = amdfs_pkg::t_vertex'($urandom_range(0, 15));
        end
        set_graph_config(amdfs_pkg::CFG_DATA_W'(count_cfg),
                         {1'($urandom_range(0, 1)), start_v});

        gap_mode = $urandom_range(0, 2);
        n_edges  = $urandom_range(1, 24);
        prev_f   = '0;
        prev_t   = '0;
        for (int k = 0; k < n_edges; k++) begin
            if (n > 0 && $urandom_range(0, 9) < 8) begin
                if (k > 0 && $urandom_range(0, 7) == 0) begin
                    f = prev_t;
                    t = prev_f;
                end else begin
                    f = amdfs_pkg::t_vertex'($urandom_range(0, n - 1));
                    t = amdfs_pkg::t_vertex'($urandom_range(0, n - 1));
                end
                pick = $urandom_range(0, 9);
                w = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF :
                    amdfs_pkg::WEIGHT_W'($urandom_range(1, 65535));
                l = (k == n_edges - 1);
            end else begin
                f = amdfs_pkg::t_vertex'($urandom_range(0, 15));
                t = amdfs_pkg::t_vertex'($urandom_range(0, 15));
                w = amdfs_pkg::WEIGHT_W'($urandom_range(0, 65535));
                l = (k == n_edges - 1) || ($urandom_range(0, 15) == 0);
            end
            case (gap_mode)
                0:       gap = 0;
                1:       gap = $urandom_range(0, MAX_GAP);
                default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
            endcase
            send_edge(f, t, w, l, gap);
            prev_f = f;
            prev_t = t;
            random_items++;
        end
        wait_idle();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = amdfs_pkg::CFG_VERTEX_COUNT;
        i_cfg_data    = '0;
        start         = 1'b0;
        i_from_vertex = '0;
        i_to_vertex   = '0;
        i_weight      = '0;
        i_last        = 1'b0;
        random_items  = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_items();
        while (random_items < RANDOM_ITEMS) begin
            random_graph();
        end

        wait_idle();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
